// ===== hdl/can_id_mask_filter_dispatch_unit_macros.svh =====
// assertion macros for the can id mask filter dispatch unit
// expects clk and rst in the scope of each use
`ifndef CAN_ID_MASK_FILTER_DISPATCH_UNIT_MACROS_SVH
`define CAN_ID_MASK_FILTER_DISPATCH_UNIT_MACROS_SVH

// condition now implies a consequence in the same cycle
`define CIMFD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// condition now implies a consequence in the next cycle
`define CIMFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/cimfd_pkg.sv =====
// shared types, codes and helpers of the can id mask filter dispatch unit
// no dependencies
package cimfd_pkg;

  localparam int unsigned FILTER_SLOTS_DEF = 16;
  localparam int unsigned ID_W             = 29;
  localparam int unsigned VEC_W            = 16;
  // wide enough for a count up to 127
  localparam int unsigned CNT_W            = 7;
  localparam int unsigned OUT_CNT_W        = 5;
  localparam logic [CNT_W-1:0] OUT_CNT_MAX = CNT_W'(31);

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_HANDLER = 2'd1,
    STATUS_FULL       = 2'd2
  } status_t;

  localparam logic [1:0] FMT_STD = 2'd0;
  localparam logic [1:0] FMT_EXT = 2'd1;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] mask;
    logic [1:0]      fmt;
  } filter_t;

  // frame query walking down the cell row
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic             ext;
    logic [CNT_W-1:0] remain;
    logic [VEC_W-1:0] pos;
    logic [VEC_W-1:0] vec;
    logic             any;
  } query_t;

  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [OUT_CNT_W-1:0] r;
    if (c > OUT_CNT_MAX) begin
      r = OUT_CNT_W'(OUT_CNT_MAX);
    end else begin
      r = c[OUT_CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/cimfd_cell.sv =====
// one filter slot of the acceptance table: holds a filter and checks a passing query
// depends on cimfd_pkg
module cimfd_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  cimfd_pkg::filter_t wr_filter,
  input  cimfd_pkg::query_t  q_in,
  output cimfd_pkg::query_t  q_out
);
  import cimfd_pkg::*;

  filter_t filt;
  query_t  q_next;
  logic    active;
  logic    fmt_ok;
  logic    hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      filt <= wr_filter;
    end
  end

  always_comb begin
    active = (q_in.remain != '0);
    fmt_ok = !(((filt.fmt == FMT_STD) && q_in.ext) || ((filt.fmt == FMT_EXT) && !q_in.ext));
    hit    = active && fmt_ok && (((q_in.id ^ filt.id) & ~filt.mask) == '0);
    q_next        = q_in;
    q_next.remain = active ? (q_in.remain - CNT_W'(1)) : '0;
    q_next.pos    = q_in.pos << 1;
    if (hit) begin
      q_next.vec = q_in.vec | q_in.pos;
      q_next.any = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_next.valid;
    end
    q_out.id     <= q_next.id;
    q_out.ext    <= q_next.ext;
    q_out.remain <= q_next.remain;
    q_out.pos    <= q_next.pos;
    q_out.vec    <= q_next.vec;
    q_out.any    <= q_next.any;
  end

endmodule

// ===== hdl/can_id_mask_filter_dispatch_unit.sv =====
// register item: the result is captured at accept and moves to the output register from hold
// frame item: the query walks down the cell row, registered in every cell, and the result is
//   captured when it leaves the last cell; the next accept waits until the output register takes it
// rst (synchronous) empties the table (count 0), clears default_enable and all valids
// filter contents are not cleared; slots at or above the count never take part
module can_id_mask_filter_dispatch_unit #(
  parameter int unsigned FILTER_SLOTS = cimfd_pkg::FILTER_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [28:0] frame_id,
  input  logic        frame_extended,
  input  logic [28:0] filter_id,
  input  logic [28:0] filter_mask,
  input  logic [1:0]  filter_format,
  input  logic        filter_has_handler,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] match_vector,
  output logic        default_taken,
  output logic [4:0]  filter_count
);
  import cimfd_pkg::*;

  `include "can_id_mask_filter_dispatch_unit_macros.svh"

  localparam int unsigned CW = $clog2(FILTER_SLOTS + 1);

  // sequencer: idle takes a transaction, walk waits for the query to leave
  // the last cell, hold waits for the output register to be free
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  logic          default_enable;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // result waiting to move into the output register
  status_t        pend_status;
  logic [VEC_W-1:0] pend_vec;
  logic           pend_def;
  logic [OUT_CNT_W-1:0] pend_count;

  logic accept;
  logic reg_ok;
  logic out_load;
  status_t reg_status;

  filter_t new_filter;
  query_t  q_chain [0:FILTER_SLOTS];
  query_t  q_tail;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_HOLD) && (!out_valid || out_ready);
  assign q_tail   = q_chain[FILTER_SLOTS];

  // register decision: missing handler wins over a full table
  always_comb begin
    reg_ok     = 1'b0;
    reg_status = STATUS_OK;
    if (!filter_has_handler) begin
      reg_status = STATUS_NO_HANDLER;
    end else if (count == CW'(FILTER_SLOTS)) begin
      reg_status = STATUS_FULL;
    end else begin
      reg_ok = 1'b1;
    end
  end

  assign new_filter = '{id: filter_id, mask: filter_mask, fmt: filter_format};

  // query enters the first cell on the accept edge of a frame
  always_comb begin
    q_chain[0].valid  = accept && kind;
    q_chain[0].id     = frame_id;
    q_chain[0].ext    = frame_extended;
    q_chain[0].remain = CNT_W'(count);
    q_chain[0].pos    = VEC_W'(1);
    q_chain[0].vec    = '0;
    q_chain[0].any    = 1'b0;
  end

  // row of filter cells, the append slot is the current count
  for (genvar i = 0; i < FILTER_SLOTS; i++) begin : g_cell
    cimfd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (accept && !kind && reg_ok && (count == CW'(i))),
      .wr_filter (new_filter),
      .q_in      (q_chain[i]),
      .q_out     (q_chain[i+1])
    );
  end

  always_comb begin
    count_next = count;
    if (accept && !kind && reg_ok) begin
      count_next = count + CW'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = kind ? ST_WALK : ST_HOLD;
        end
      end
      ST_WALK: begin
        if (q_tail.valid) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      count          <= '0;
      default_enable <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_we) begin
        default_enable <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending result: register transactions at accept, frames when the query leaves the row
  always_ff @(posedge clk) begin
    if (accept && !kind) begin
      pend_status <= reg_status;
      pend_vec    <= '0;
      pend_def    <= 1'b0;
      pend_count  <= sat_count(CNT_W'(count_next));
    end else if ((state == ST_WALK) && q_tail.valid) begin
      pend_status <= STATUS_OK;
      pend_vec    <= q_tail.vec;
      pend_def    <= !q_tail.any && default_enable;
      pend_count  <= sat_count(CNT_W'(count));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= pend_status;
      match_vector  <= pend_vec;
      default_taken <= pend_def;
      filter_count  <= pend_count;
    end
  end

  `CIMFD_ASSERT_NEXT(a_accept_leaves_idle, accept, !in_ready,
    "input taken while a transaction is in flight")
  `CIMFD_ASSERT_NOW(a_tail_only_in_walk, q_tail.valid, state == ST_WALK,
    "query left the cell row outside of a frame walk")
  `CIMFD_ASSERT_NOW(a_count_in_range, 1'b1, count <= CW'(FILTER_SLOTS),
    "filter count beyond table size")
  `CIMFD_ASSERT_NOW(a_default_no_match, out_valid && default_taken, match_vector == '0,
    "default route taken with a filter match")

endmodule

// ===== bench/tb.sv =====
// self-checking bench for can_id_mask_filter_dispatch_unit: filter registration,
// frame classification and the default route, checked against an in-bench predictor
// depends on cimfd_pkg and the unit under test
`timescale 1ns / 100ps

module tb;
  import cimfd_pkg::*;

  localparam int unsigned SLOTS = FILTER_SLOTS_DEF;
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_FRAME    = 1'b1;
  // format codes that accept both frame types
  localparam logic [1:0] FMT_ANY     = 2'd2;
  localparam logic [1:0] FMT_ANY_ALT = 2'd3;
  localparam logic [ID_W-1:0] ID_ALL = {ID_W{1'b1}};

  // one input transaction as presented on the input channel
  typedef struct {
    logic            kind;
    logic [ID_W-1:0] frame_id;
    logic            frame_ext;
    logic [ID_W-1:0] flt_id;
    logic [ID_W-1:0] flt_mask;
    logic [1:0]      flt_fmt;
    logic            has_handler;
  } filter_txn_t;

  // one result transaction
  typedef struct {
    status_t              status;
    logic [VEC_W-1:0]     vec;
    logic                 dflt;
    logic [OUT_CNT_W-1:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic kind = 1'b0;
  logic [28:0] frame_id = '0;
  logic frame_extended = 1'b0;
  logic [28:0] filter_id = '0;
  logic [28:0] filter_mask = '0;
  logic [1:0] filter_format = '0;
  logic filter_has_handler = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [15:0] match_vector;
  logic default_taken;
  logic [4:0] filter_count;

  // shadow of the acceptance table and the default route register
  logic [ID_W-1:0] tbl_id [SLOTS];
  logic [ID_W-1:0] tbl_mask [SLOTS];
  logic [1:0]      tbl_fmt [SLOTS];
  int              tbl_count = 0;
  logic            dflt_en = 1'b0;

  filter_txn_t pending_q [$];   // transactions waiting for the driver
  verdict_t    verdict_q [$];   // predicted results in acceptance order
  filter_txn_t cur_txn;
  int          idle_left = 0;
  int          stall_left = 0;
  bit          burst_mode = 1'b0;

  // filters handed out by the generator, used to aim frames at real entries
  logic [ID_W-1:0] hint_id [$];
  logic [ID_W-1:0] hint_mask [$];

  int err_count = 0;
  int n_reg_ok = 0;
  int n_reg_rej = 0;
  int n_frames = 0;
  int n_hit = 0;
  int n_dflt = 0;

  can_id_mask_filter_dispatch_unit i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .kind               (kind),
    .frame_id           (frame_id),
    .frame_extended     (frame_extended),
    .filter_id          (filter_id),
    .filter_mask        (filter_mask),
    .filter_format      (filter_format),
    .filter_has_handler (filter_has_handler),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .status             (status),
    .match_vector       (match_vector),
    .default_taken      (default_taken),
    .filter_count       (filter_count)
  );

  always #5 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("tb failed");
    $finish;
  end

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  // registration appends to the table, a frame walks every stored entry
  function automatic verdict_t predict_verdict(input filter_txn_t t);
    verdict_t v;
    logic [ID_W-1:0] care;
    logic hit;
    logic any;
    v.status = STATUS_OK;
    v.vec = '0;
    v.dflt = 1'b0;
    any = 1'b0;
    if (t.kind == KIND_REGISTER) begin
      // missing handler wins over a full table
      if (!t.has_handler) begin
        v.status = STATUS_NO_HANDLER;
      end else if (tbl_count >= SLOTS) begin
        v.status = STATUS_FULL;
      end else begin
        tbl_id[tbl_count] = t.flt_id;
        tbl_mask[tbl_count] = t.flt_mask;
        tbl_fmt[tbl_count] = t.flt_fmt;
        tbl_count++;
      end
      if (v.status == STATUS_OK) n_reg_ok++;
      else n_reg_rej++;
    end else begin
      for (int i = 0; i < tbl_count; i++) begin
        care = ~tbl_mask[i];
        hit = ((t.frame_id & care) == (tbl_id[i] & care));
        if (tbl_fmt[i] == FMT_STD && t.frame_ext) hit = 1'b0;
        if (tbl_fmt[i] == FMT_EXT && !t.frame_ext) hit = 1'b0;
        if (hit) begin
          any = 1'b1;
          v.vec[i] = 1'b1;
        end
      end
      v.dflt = !any && dflt_en;
      n_frames++;
      if (any) n_hit++;
      if (v.dflt) n_dflt++;
    end
    v.count = (tbl_count > 31) ? OUT_CNT_W'(31) : OUT_CNT_W'(tbl_count);
    return v;
  endfunction

  // mostly back to back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: presents pending transactions, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        verdict_q.push_back(predict_verdict(cur_txn));
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_txn = pending_q.pop_front();
          kind <= cur_txn.kind;
          frame_id <= cur_txn.frame_id;
          frame_extended <= cur_txn.frame_ext;
          filter_id <= cur_txn.flt_id;
          filter_mask <= cur_txn.flt_mask;
          filter_format <= cur_txn.flt_fmt;
          filter_has_handler <= cur_txn.has_handler;
          in_valid <= 1'b1;
          idle_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input verdict_t e);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t mismatch (%s): exp status %0d vec %04h dflt %0b cnt %0d", $realtime,
               what, e.status, e.vec, e.dflt, e.count);
      $display("%0t          got status %0d vec %04h dflt %0b cnt %0d", $realtime,
               status, match_vector, default_taken, filter_count);
    end
  endtask

  // monitor: checks each accepted result and throttles out_ready
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          e = '{STATUS_OK, '0, 1'b0, '0};
          report_mismatch("unexpected result", e);
        end else begin
          e = verdict_q.pop_front();
          if (status !== e.status || match_vector !== e.vec ||
              default_taken !== e.dflt || filter_count !== e.count) begin
            report_mismatch("field", e);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!burst_mode && $urandom_range(0, 99) < 15) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // unused fields carry random noise
  function automatic filter_txn_t noise_txn();
    filter_txn_t t;
    t.kind = 1'($urandom);
    t.frame_id = rand_id();
    t.frame_ext = 1'($urandom);
    t.flt_id = rand_id();
    t.flt_mask = rand_id();
    t.flt_fmt = 2'($urandom);
    t.has_handler = 1'($urandom);
    return t;
  endfunction

  function automatic filter_txn_t make_reg(input logic [ID_W-1:0] id,
                                           input logic [ID_W-1:0] mask,
                                           input logic [1:0] fmt, input logic handler);
    filter_txn_t t;
    t = noise_txn();
    t.kind = KIND_REGISTER;
    t.flt_id = id;
    t.flt_mask = mask;
    t.flt_fmt = fmt;
    t.has_handler = handler;
    return t;
  endfunction

  function automatic filter_txn_t make_frame(input logic [ID_W-1:0] id, input logic ext);
    filter_txn_t t;
    t = noise_txn();
    t.kind = KIND_FRAME;
    t.frame_id = id;
    t.frame_ext = ext;
    return t;
  endfunction

  // exact, wildcard, sparse, low-field, random and dense masks
  function automatic logic [ID_W-1:0] pick_mask();
    logic [ID_W-1:0] m;
    case ($urandom_range(0, 5))
      0: m = '0;
      1: m = ID_ALL;
      2: m = rand_id() & rand_id() & rand_id();
      3: m = (ID_W'(1) << $urandom_range(0, 28)) - ID_W'(1);
      4: m = rand_id();
      default: m = ~(rand_id() & rand_id());
    endcase
    return m;
  endfunction

  task automatic gen_random(input int n, input int reg_pct);
    filter_txn_t t;
    int k;
    int b;
    int r;
    for (int j = 0; j < n; j++) begin
      t = noise_txn();
      if ($urandom_range(0, 99) < reg_pct) begin
        t.kind = KIND_REGISTER;
        t.flt_mask = pick_mask();
        t.has_handler = ($urandom_range(0, 99) < 85);
        if (t.has_handler && hint_id.size() < SLOTS) begin
          hint_id.push_back(t.flt_id);
          hint_mask.push_back(t.flt_mask);
        end
      end else begin
        t.kind = KIND_FRAME;
        r = $urandom_range(0, 99);
        if (hint_id.size() > 0 && r < 70) begin
          // aim at a stored filter, sometimes flip one random id bit
          k = $urandom_range(0, hint_id.size() - 1);
          t.frame_id = hint_id[k] ^ (rand_id() & hint_mask[k]);
          if ($urandom_range(0, 4) == 0) begin
            b = $urandom_range(0, ID_W - 1);
            t.frame_id[b] = ~t.frame_id[b];
          end
        end else if (r < 85) begin
          t.frame_id = ID_W'($urandom_range(0, 2047));
        end
      end
      pending_q.push_back(t);
    end
  endtask

  // sender holds off until every result is back
  task automatic drain();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0);
  endtask

  task automatic write_default_enable(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dflt_en = v;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_default_enable(1'b0);

    // directed, default route off
    pending_q.push_back(make_frame('0, 1'b0));                       // empty table
    pending_q.push_back(make_reg(rand_id(), rand_id(), FMT_ANY, 1'b0)); // no handler
    pending_q.push_back(make_reg(ID_ALL, '0, FMT_STD, 1'b1));
    pending_q.push_back(make_reg('0, ID_ALL, FMT_EXT, 1'b1));        // any extended frame
    pending_q.push_back(make_reg(29'h123, '0, FMT_ANY, 1'b1));
    pending_q.push_back(make_reg(29'h5A5A5A5, 29'h0F0F0F0, FMT_ANY_ALT, 1'b1));
    pending_q.push_back(make_frame(ID_ALL, 1'b0));
    pending_q.push_back(make_frame(ID_ALL, 1'b1));
    pending_q.push_back(make_frame(29'h123, 1'b0));
    pending_q.push_back(make_frame(29'h123, 1'b1));
    pending_q.push_back(make_frame(29'h5A5A5A5 ^ 29'h0F0F0F0, 1'b0));
    pending_q.push_back(make_frame(29'h1FFFFFFE, 1'b0));             // one care bit off
    drain();

    // directed, default route on
    write_default_enable(1'b1);
    pending_q.push_back(make_frame(29'h1FFFFFFE, 1'b0));             // falls to default
    pending_q.push_back(make_frame('0, 1'b1));
    pending_q.push_back(make_frame(29'h5A5A5A5, 1'b1));
    pending_q.push_back(make_reg(rand_id(), rand_id(), FMT_ANY_ALT, 1'b0));
    drain();
    hint_id = '{ID_ALL, '0, 29'h123, 29'h5A5A5A5};
    hint_mask = '{29'h0, ID_ALL, 29'h0, 29'h0F0F0F0};

    // random phases, alternating default route; table fills in the first one
    for (int p = 0; p < 6; p++) begin
      write_default_enable(p[0] ? 1'b0 : 1'b1);
      burst_mode = (p == 3);
      gen_random(305, (p == 0) ? 8 : 10);
      drain();
    end
    burst_mode = 1'b0;

    repeat (40) @(posedge clk);
    $display("covered %0d filter registrations (%0d rejected) and %0d frames",
             n_reg_ok + n_reg_rej, n_reg_rej, n_frames);
    $display("  %0d frames hit a filter, %0d took the default route", n_hit, n_dflt);
    if (err_count == 0 && verdict_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
